FILE: rtl/lbct_pkg.sv
`default_nettype none

package lbct_pkg;

	localparam int CMD_W    = 3;
	localparam int TAG_W    = 32;
	localparam int STAMP_W  = 32;
	localparam int ACTIVE_W = 5;
	localparam int SLOT_W   = 4;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOP     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PICK    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MARK    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

	localparam logic [TAG_W-1:0]    TAG_UNUSED   = '1;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
	localparam logic                REG_ACTIVE   = 1'b0;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_MATCH,
		RES_UNUSED,
		RES_BEST,
		RES_ECHO
	} res_sel_t;

	typedef struct packed {
		logic     scan_start;
		logic     scan_run;
		logic     mark_wr;
		logic     mark_unused;
		logic     inv_wr;
		logic     res_load;
		res_sel_t res_sel;
	} ctrl_t;

	typedef struct packed {
		logic pipe_busy;
		logic found_match;
		logic found_unused;
		logic in_range;
	} stat_t;

endpackage

`default_nettype wire

FILE: rtl/lru_block_cache_tags_top.sv
`default_nettype none

// Tag and recency table for a small fully associative cache with LRU replacement.
// A command transfer is taken at a clock edge where start is high and busy is low.
// Lookup, lookup-or-pick and pick scan the active slots one per cycle through the
// tag and stamp RAMs and a two-stage compare pipeline; with N the clamped active
// slot count, busy stays high from the transfer until the scan of the N slots has
// drained, and the result appears as busy falls, so no command is taken meanwhile.
// Mark-used, release and undefined commands finish at once: their result appears
// the cycle after the transfer and a new command may follow every cycle.
// Each result is shown on slot_out and hit for exactly one cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle.
// The APB port holds the active slot count at byte address 0 and should be written
// only while no command is outstanding.
// Reset clears the valid bits, so every tag reads as unused and every stamp as zero,
// clears the use counter and sets the active slot count to 16; no clearing pass is needed.
module lru_block_cache_tags_top
	import lbct_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [TAG_W-1:0]   block_number,
	input  logic [SLOT_W-1:0]  slot_index,
	output logic               done,
	output logic [SLOT_W-1:0]  slot_out,
	output logic               hit
);

	logic [ACTIVE_W-1:0] active_q;
	ctrl_t               ctrl;
	stat_t               stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_ACTIVE) begin
			active_q <= pwdata[ACTIVE_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_ACTIVE) ? DATA_W'(active_q) : '0;

	lbct_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.ctrl    (ctrl),
		.busy    (busy),
		.done    (done)
	);

	lbct_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.active       (active_q),
		.block_number (block_number),
		.slot_index   (slot_index),
		.slot_out     (slot_out),
		.hit          (hit)
	);

`ifndef ASSERT_OFF
	a_quick_result : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command != CMD_LOOKUP && command != CMD_LOP &&
			command != CMD_PICK) |=> (done && !hit && !busy))
		else $error("quick command did not complete in one cycle");

	a_scan_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_LOOKUP || command == CMD_LOP ||
			command == CMD_PICK)) |=> (busy && !done))
		else $error("scan command did not enter the scan");

	a_scan_end : assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result");

	a_done_source : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without a command");
`endif

endmodule

`default_nettype wire

FILE: rtl/lbct_ram.sv
`default_nettype none

module lbct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/lbct_ctrl.sv
`default_nettype none

module lbct_ctrl
	import lbct_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] command,
	input  stat_t            stat,
	output ctrl_t            ctrl,
	output logic             busy,
	output logic             done
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CMD_W-1:0] cmd_q;
	logic             done_q;

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (command)
						CMD_LOOKUP, CMD_LOP, CMD_PICK: begin
							ctrl.scan_start = 1'b1;
							state_d         = ST_SCAN;
						end
						CMD_MARK, CMD_RELEASE: begin
							ctrl.mark_wr     = stat.in_range;
							ctrl.mark_unused = (command == CMD_RELEASE);
							ctrl.res_load    = 1'b1;
							ctrl.res_sel     = RES_ECHO;
						end
						default: begin
							ctrl.res_load = 1'b1;
							ctrl.res_sel  = RES_ZERO;
						end
					endcase
				end
			end
			ST_SCAN: begin
				ctrl.scan_run = 1'b1;
				if (!stat.pipe_busy) begin
					ctrl.res_load = 1'b1;
					state_d       = ST_IDLE;
					if (stat.found_match && cmd_q != CMD_PICK) begin
						ctrl.res_sel = RES_MATCH;
					end else if (cmd_q == CMD_LOOKUP) begin
						ctrl.res_sel = RES_ZERO;
					end else if (stat.found_unused) begin
						ctrl.res_sel = RES_UNUSED;
					end else begin
						ctrl.res_sel = RES_BEST;
						ctrl.inv_wr  = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_LOOKUP;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctrl.res_load;
			if (ctrl.scan_start) begin
				cmd_q <= command;
			end
		end
	end

	assign busy = (state_q == ST_SCAN);
	assign done = done_q;

endmodule

`default_nettype wire

FILE: rtl/lbct_dp.sv
`default_nettype none

module lbct_dp
	import lbct_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	output stat_t               stat,
	input  logic [ACTIVE_W-1:0] active,
	input  logic [TAG_W-1:0]    block_number,
	input  logic [SLOT_W-1:0]   slot_index,
	output logic [SLOT_W-1:0]   slot_out,
	output logic                hit
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int NW    = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
	localparam int AW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
		logic [AW-1:0] w;
		w = AW'(i);
		return w[SLOT_W-1:0];
	endfunction

	logic [NW-1:0]      act_w;
	logic [NW-1:0]      n_w;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               issue;
	logic [AW-1:0]      slot_ext;
	logic [IDX_W-1:0]   mark_addr;
	logic [SLOTS-1:0]   valid_q;
	logic [STAMP_W-1:0] counter_q;
	logic [TAG_W-1:0]   key_q;

	logic               tag_we;
	logic [IDX_W-1:0]   tag_waddr;
	logic [TAG_W-1:0]   tag_wdata;
	logic [TAG_W-1:0]   tag_rd;
	logic [STAMP_W-1:0] stamp_rd;
	logic [STAMP_W-1:0] stamp_next;

	logic               vld_s1;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [STAMP_W-1:0] stamp_s1;

	logic               vld_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic               match_s2;
	logic               unused_s2;
	logic [STAMP_W-1:0] age_s2;

	logic               found_match_q;
	logic               found_unused_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [IDX_W-1:0]   unused_idx_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] best_age_q;

	logic [SLOT_W-1:0]  slot_q;
	logic               hit_q;

	always_comb begin
		act_w = NW'(active);
		if (act_w == '0) begin
			n_w = NW'(1);
		end else if (act_w > NW'(SLOTS)) begin
			n_w = NW'(SLOTS);
		end else begin
			n_w = act_w;
		end
	end

	assign issue      = ctrl.scan_run && (rd_idx_q < n_q);
	assign slot_ext   = AW'(slot_index);
	assign mark_addr  = slot_ext[IDX_W-1:0];
	assign stamp_next = counter_q + STAMP_W'(1);

	assign tag_we    = ctrl.mark_wr || ctrl.inv_wr;
	assign tag_waddr = ctrl.inv_wr ? best_idx_q : mark_addr;
	assign tag_wdata = (ctrl.inv_wr || ctrl.mark_unused) ? TAG_UNUSED : block_number;

	lbct_ram #(
		.WIDTH (TAG_W),
		.DEPTH (SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (tag_rd)
	);

	lbct_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (SLOTS)
	) u_stamp_ram (
		.clk   (clk),
		.we    (ctrl.mark_wr),
		.waddr (mark_addr),
		.wdata (stamp_next),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (stamp_rd)
	);

	assign tag_s1   = valid_s1 ? tag_rd : TAG_UNUSED;
	assign stamp_s1 = valid_s1 ? stamp_rd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			counter_q      <= '0;
			n_q            <= '0;
			rd_idx_q       <= '0;
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			found_match_q  <= 1'b0;
			found_unused_q <= 1'b0;
			best_age_q     <= '0;
			best_idx_q     <= '0;
		end else begin
			if (ctrl.mark_wr) begin
				valid_q[mark_addr] <= 1'b1;
				counter_q          <= stamp_next;
			end
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (ctrl.scan_start) begin
				n_q            <= n_w[CNT_W-1:0];
				rd_idx_q       <= '0;
				found_match_q  <= 1'b0;
				found_unused_q <= 1'b0;
				best_age_q     <= '0;
				best_idx_q     <= '0;
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (vld_s2) begin
					if (match_s2 && !found_match_q) begin
						found_match_q <= 1'b1;
					end
					if (unused_s2 && !found_unused_q) begin
						found_unused_q <= 1'b1;
					end
					if (age_s2 > best_age_q) begin
						best_age_q <= age_s2;
						best_idx_q <= idx_s2;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan_start) begin
			key_q <= block_number;
		end
		valid_s1  <= valid_q[rd_idx_q[IDX_W-1:0]];
		idx_s1    <= rd_idx_q[IDX_W-1:0];
		idx_s2    <= idx_s1;
		match_s2  <= (tag_s1 == key_q);
		unused_s2 <= (tag_s1 == TAG_UNUSED);
		age_s2    <= counter_q - stamp_s1;
		if (vld_s2 && match_s2 && !found_match_q) begin
			match_idx_q <= idx_s2;
		end
		if (vld_s2 && unused_s2 && !found_unused_q) begin
			unused_idx_q <= idx_s2;
		end
		if (ctrl.res_load) begin
			case (ctrl.res_sel)
				RES_MATCH: begin
					slot_q <= to_slot(match_idx_q);
					hit_q  <= 1'b1;
				end
				RES_UNUSED: begin
					slot_q <= to_slot(unused_idx_q);
					hit_q  <= 1'b0;
				end
				RES_BEST: begin
					slot_q <= to_slot(best_idx_q);
					hit_q  <= 1'b0;
				end
				RES_ECHO: begin
					slot_q <= slot_index;
					hit_q  <= 1'b0;
				end
				default: begin
					slot_q <= '0;
					hit_q  <= 1'b0;
				end
			endcase
		end
	end

	assign stat.pipe_busy    = issue || vld_s1 || vld_s2;
	assign stat.found_match  = found_match_q;
	assign stat.found_unused = found_unused_q;
	assign stat.in_range     = (NW'(slot_index) < n_w);

	assign slot_out = slot_q;
	assign hit      = hit_q;

endmodule

`default_nettype wire

FILE: bench/lru_block_cache_tags_top_test.sv
module lru_block_cache_tags_top_test;
	import lbct_pkg::*;

	localparam int SLOT_COUNT = 16;
	localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNDEF_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNDEF_LAST = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = SLOT_COUNT + 8;
	localparam int POOL_SIZE = 24;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
	} slot_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic [CMD_W-1:0]   command;
	logic [TAG_W-1:0]   block_number;
	logic [SLOT_W-1:0]  slot_index;
	logic               done;
	logic [SLOT_W-1:0]  slot_out;
	logic               hit;

	logic [TAG_W-1:0]    model_tag [SLOT_COUNT];
	logic [STAMP_W-1:0]  model_stamp [SLOT_COUNT];
	logic [STAMP_W-1:0]  model_counter;
	logic [ACTIVE_W-1:0] model_active;
	logic [TAG_W-1:0]    block_pool [POOL_SIZE];
	slot_result_t        pending_slots [$];
	int                  mismatch_count;
	int                  cycle_count;
	int                  idle_pct;

	lru_block_cache_tags_top #(
		.SLOTS(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.command(command),
		.block_number(block_number),
		.slot_index(slot_index),
		.done(done),
		.slot_out(slot_out),
		.hit(hit)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int scanned_slots();
		int n;
		n = model_active;
		if (n < 1)
			n = 1;
		if (n > SLOT_COUNT)
			n = SLOT_COUNT;
		return n;
	endfunction

	function automatic logic [SLOT_W-1:0] evict_victim();
		int n;
		int victim;
		logic [STAMP_W-1:0] age;
		logic [STAMP_W-1:0] oldest;
		n = scanned_slots();
		victim = 0;
		oldest = '0;
		for (int i = 0; i < n; i++) begin
			if (model_tag[i] == TAG_UNUSED)
				return SLOT_W'(i);
			age = model_counter - model_stamp[i];
			if (age > oldest) begin
				oldest = age;
				victim = i;
			end
		end
		model_tag[victim] = TAG_UNUSED;
		return SLOT_W'(victim);
	endfunction

	function automatic slot_result_t predict_slot_result(input logic [CMD_W-1:0] cmd,
			input logic [TAG_W-1:0] blk, input logic [SLOT_W-1:0] idx);
		slot_result_t r;
		int n;
		bit found;
		r = '0;
		n = scanned_slots();
		found = 1'b0;
		case (cmd)
			CMD_LOOKUP, CMD_LOP: begin
				for (int i = 0; i < n && !found; i++) begin
					if (model_tag[i] == blk) begin
						found = 1'b1;
						r.slot = SLOT_W'(i);
						r.hit = 1'b1;
					end
				end
				if (!found && cmd == CMD_LOP)
					r.slot = evict_victim();
			end
			CMD_PICK: begin
				r.slot = evict_victim();
			end
			CMD_MARK, CMD_RELEASE: begin
				if (int'(idx) < n) begin
					model_tag[idx] = (cmd == CMD_MARK) ? blk : TAG_UNUSED;
					model_counter = model_counter + 1'b1;
					model_stamp[idx] = model_counter;
				end
				r.slot = idx;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatch_count++;
	endtask

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] blk,
			input logic [SLOT_W-1:0] idx);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		block_number <= blk;
		slot_index <= idx;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_slots.push_back(predict_slot_result(cmd, blk, idx));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_slots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_active_slots(input logic [DATA_W-1:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * REG_ACTIVE);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		model_active = value[ACTIVE_W-1:0];
	endtask

	always @(posedge clk) begin : check_results
		slot_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_slots.size() == 0) begin
				report_mismatch("unexpected result slot_out", 32'(slot_out), 32'hx);
			end else begin
				want = pending_slots.pop_front();
				if (slot_out !== want.slot)
					report_mismatch("slot_out", 32'(slot_out), 32'(want.slot));
				if (hit !== want.hit)
					report_mismatch("hit", 32'(hit), 32'(want.hit));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_directed_commands();
		idle_pct = 0;
		send_command(CMD_LOOKUP, 32'h0000_0000, 4'h0);
		send_command(CMD_LOOKUP, TAG_UNUSED, 4'hf);
		send_command(CMD_PICK, 32'h0000_0000, 4'h0);
		send_command(CMD_LOP, 32'h1234_5678, 4'h0);
		send_command(CMD_MARK, 32'h0000_0000, 4'h0);
		send_command(CMD_MARK, 32'hffff_fffe, 4'hf);
		send_command(CMD_MARK, 32'h8000_0000, 4'h7);
		send_command(CMD_LOOKUP, 32'h0000_0000, 4'h0);
		send_command(CMD_LOOKUP, 32'hffff_fffe, 4'h0);
		send_command(CMD_LOP, 32'h8000_0000, 4'h0);
		send_command(CMD_RELEASE, 32'hffff_ffff, 4'h7);
		send_command(CMD_LOOKUP, TAG_UNUSED, 4'h0);
		send_command(CMD_UNDEF_FIRST, 32'hffff_ffff, 4'hf);
		send_command(CMD_UNDEF_MID, 32'h5555_aaaa, 4'ha);
		send_command(CMD_UNDEF_LAST, 32'h0000_0000, 4'h5);
		send_command(CMD_MARK, TAG_UNUSED, 4'hf);
		send_command(CMD_PICK, 32'h0000_0000, 4'h0);
	endtask

	task automatic test_lru_eviction();
		idle_pct = 0;
		write_active_slots(32'd3);
		send_command(CMD_MARK, 32'h0000_0a0a, 4'h0);
		send_command(CMD_MARK, 32'h0000_0b0b, 4'h1);
		send_command(CMD_MARK, 32'h0000_0c0c, 4'h2);
		send_command(CMD_LOOKUP, 32'h0000_0a0a, 4'h0);
		send_command(CMD_PICK, 32'h0000_0000, 4'h0);
		send_command(CMD_LOP, 32'h0000_0a0a, 4'h0);
		send_command(CMD_MARK, 32'h0000_0a0a, 4'h0);
		send_command(CMD_PICK, 32'h0000_0000, 4'h0);
		send_command(CMD_MARK, 32'h0000_0d0d, 4'h9);
		send_command(CMD_RELEASE, 32'h0000_0000, 4'hc);
		write_active_slots(32'd1);
		send_command(CMD_MARK, 32'h0000_0e0e, 4'h0);
		send_command(CMD_PICK, 32'h0000_0000, 4'h0);
		send_command(CMD_PICK, 32'h0000_0000, 4'h0);
	endtask

	task automatic test_random_traffic();
		logic [DATA_W-1:0] settings [8];
		int pick;
		logic [CMD_W-1:0] cmd;
		logic [TAG_W-1:0] blk;
		logic [SLOT_W-1:0] idx;
		block_pool[0] = 32'h0000_0000;
		block_pool[1] = TAG_UNUSED;
		block_pool[2] = 32'hffff_fffe;
		block_pool[3] = 32'h8000_0000;
		for (int i = 4; i < POOL_SIZE; i++)
			block_pool[i] = $urandom();
		settings = '{32'd16, 32'd0, 32'd1, 32'd31, 32'd17, 32'd2, 32'd8, 32'd0};
		settings[7] = $urandom_range(31, 0);
		foreach (settings[s]) begin
			write_active_slots(settings[s]);
			for (int k = 0; k < 100; k++) begin
				if (k < 34)
					idle_pct = 0;
				else if (k < 67)
					idle_pct = 87;
				else
					idle_pct = 19;
				pick = $urandom_range(99);
				if (pick < 20)
					cmd = CMD_LOOKUP;
				else if (pick < 38)
					cmd = CMD_LOP;
				else if (pick < 50)
					cmd = CMD_PICK;
				else if (pick < 80)
					cmd = CMD_MARK;
				else if (pick < 92)
					cmd = CMD_RELEASE;
				else
					cmd = CMD_W'($urandom_range(CMD_UNDEF_LAST, CMD_UNDEF_FIRST));
				if ($urandom_range(99) < 85)
					blk = block_pool[$urandom_range(POOL_SIZE - 1)];
				else
					blk = $urandom();
				if ($urandom_range(99) < 80)
					idx = SLOT_W'($urandom_range(scanned_slots() - 1));
				else
					idx = SLOT_W'($urandom_range(SLOT_COUNT - 1));
				send_command(cmd, blk, idx);
			end
		end
	endtask

	initial begin
		start <= 1'b0;
		command <= CMD_LOOKUP;
		block_number <= '0;
		slot_index <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			model_tag[i] = TAG_UNUSED;
			model_stamp[i] = '0;
		end
		model_counter = '0;
		model_active = ACTIVE_RESET;
		idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_lru_eviction();
		test_random_traffic();
		wait_drained();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
